FILE: src/kalman_tracker_pos_vel_assert.svh
// assertion macros for the tracker checker
`ifndef KALMAN_TRACKER_POS_VEL_ASSERT_SVH
`define KALMAN_TRACKER_POS_VEL_ASSERT_SVH
// implication checked on every clock edge outside reset
`define KT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define KT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/kt_pkg.sv
// ----------------------------------------------------------------------------
// kt_pkg
// types and constants shared by the tracker modules
// ----------------------------------------------------------------------------
package kt_pkg;
    localparam logic [1:0] REQ_PREDICT = 2'd0;
    localparam logic [1:0] REQ_UPDATE  = 2'd1;
    localparam logic [1:0] REQ_BOTH    = 2'd2;
    localparam logic [1:0] REQ_NOOP    = 2'd3;

    localparam logic [2:0] CFG_DT     = 3'd0;
    localparam logic [2:0] CFG_Q      = 3'd1;
    localparam logic [2:0] CFG_R      = 3'd2;
    localparam logic [2:0] CFG_POS    = 3'd3;
    localparam logic [2:0] CFG_VEL    = 3'd4;
    localparam logic [2:0] CFG_PVAR   = 3'd5;
    localparam logic [2:0] CFG_VVAR   = 3'd6;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // datapath micro-operations
    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_P_M00   = 5'd1;  // t0 = sat(P00 + dt*P01)
    localparam logic [4:0] OP_P_C     = 5'd2;  // P01 = sat(P01 + dt*P11)
    localparam logic [4:0] OP_P_P00   = 5'd3;  // P00 = satv(t0 + dt*P01 + q), P11
    localparam logic [4:0] OP_P_POS   = 5'd4;  // p = sat(p + dt*v)
    localparam logic [4:0] OP_U_S     = 5'd5;  // s, residual, flag
    localparam logic [4:0] OP_U_DIV0  = 5'd6;  // start div P00/s
    localparam logic [4:0] OP_U_K0    = 5'd7;  // capture k0, start P01/s
    localparam logic [4:0] OP_U_K1    = 5'd8;  // capture k1
    localparam logic [4:0] OP_U_POS   = 5'd9;  // p += k0*res
    localparam logic [4:0] OP_U_VEL   = 5'd10; // v += k1*res
    localparam logic [4:0] OP_U_AB    = 5'd11; // a, b
    localparam logic [4:0] OP_U_M00   = 5'd12;
    localparam logic [4:0] OP_U_M01   = 5'd13;
    localparam logic [4:0] OP_U_M10   = 5'd14;
    localparam logic [4:0] OP_U_M11   = 5'd15;
    localparam logic [4:0] OP_U_KR0   = 5'd16;
    localparam logic [4:0] OP_U_KR1   = 5'd17;
    localparam logic [4:0] OP_U_C00A  = 5'd18; // acc = m00*a
    localparam logic [4:0] OP_U_C00B  = 5'd19; // P00n = satv(acc + kr0*k0)
    localparam logic [4:0] OP_U_C01A  = 5'd20; // acc = m00*b + m01
    localparam logic [4:0] OP_U_C01B  = 5'd21; // P01n
    localparam logic [4:0] OP_U_C11A  = 5'd22; // acc = m10*b + m11
    localparam logic [4:0] OP_U_C11B  = 5'd23; // P11n, commit covariance

    typedef struct packed {
        logic [4:0] op;
    } kt_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic singular;
    } kt_stat_t;
endpackage

FILE: src/kt_if.sv
// ----------------------------------------------------------------------------
// kt_in_if / kt_out_if
// valid/ready channels of the tracker
// ----------------------------------------------------------------------------
interface kt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic signed [31:0] measured_position;
    modport source (output valid, req_type, measured_position, input ready);
    modport sink   (input valid, req_type, measured_position, output ready);
endinterface

interface kt_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] position_estimate;
    logic signed [31:0] velocity_estimate;
    logic [30:0] position_uncertainty;
    logic        singular_flag;
    modport source (output valid, position_estimate, velocity_estimate,
                    position_uncertainty, singular_flag, input ready);
    modport sink   (input valid, position_estimate, velocity_estimate,
                    position_uncertainty, singular_flag, output ready);
endinterface

FILE: src/kt_div.sv
// ----------------------------------------------------------------------------
// kt_div
// restoring divider for the gain, one quotient bit per cycle, rounded
// ----------------------------------------------------------------------------
module kt_div
    import kt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [31:0]        den,
    output logic               busy,
    output logic signed [31:0] quo
);
    localparam int NB = 32 + FRAC_BITS;   // dividend bits
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]  dvd_reg, dvd_next;
    logic [NB-1:0]  q_reg, q_next;
    logic [32:0]    rem_reg, rem_next;
    logic [31:0]    den_reg, den_next;
    logic           neg_reg, neg_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;

    logic [31:0]    mag;
    logic [33:0]    trial;
    logic [NB:0]    qr;
    logic [NB:0]    qsat;
    logic [32:0]    twice;

    assign mag = num[31] ? 32'(-num) : 32'(num);

    // shift-subtract step
    always_comb
    begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (start)
        begin
            dvd_next  = {mag, FRAC_BITS'(0)};
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[31];
            cnt_next  = CW'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, dvd_reg[NB-1]} - {2'b00, den_reg};
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                q_next   = {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], dvd_reg[NB-1]};
                q_next   = {q_reg[NB-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[NB-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    // round half up on magnitude: remainder*2 >= den
    assign twice = {rem_reg[31:0], 1'b0};
    assign qr    = {1'b0, q_reg} + ((rem_reg[32] || twice >= {1'b0, den_reg})
                                    ? (NB+1)'(1) : (NB+1)'(0));
    assign qsat  = (qr > (NB+1)'(33'h80000000)) ? (NB+1)'(33'h80000000) : qr;

    always_comb
    begin
        if (neg_reg)
            quo = 32'(-qsat[31:0]) ;
        else if (qsat[31])
            quo = 32'sh7fffffff;
        else
            quo = qsat[31:0];
        if (neg_reg && qsat[32])
            quo = 32'sh80000000;
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end
endmodule

FILE: src/kt_datapath.sv
// ----------------------------------------------------------------------------
// kt_datapath
// state, configuration, one shared multiplier and the divider, stepped by the controller
// ----------------------------------------------------------------------------
module kt_datapath
    import kt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               load_z,
    input  logic signed [31:0] z_in,
    input  kt_cmd_t            cmd,
    output kt_stat_t           stat,
    output logic signed [31:0] pos,
    output logic signed [31:0] vel,
    output logic [30:0]        pvar
);
    localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [33:0] ONE  = 34'sd1 <<< FRAC_BITS;

    logic [30:0] dt_reg, q_reg, r_reg;
    logic [30:0] ipv_reg, ivv_reg;
    logic signed [31:0] ip_reg, iv_reg;
    logic signed [31:0] p_reg, v_reg, c00_reg, c01_reg, c11_reg;
    logic signed [31:0] n00_reg, n01_reg;
    logic signed [31:0] t0_reg, k0_reg, k1_reg, a_reg, b_reg;
    logic signed [31:0] m00_reg, m01_reg, m10_reg, m11_reg, kr0_reg, kr1_reg;
    logic signed [32:0] res_reg, z_reg;
    logic signed [31:0] s_den_reg;
    logic [31:0]        s_mag_reg;
    logic               sing_reg;
    logic signed [34:0] acc_reg;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] mp;
    logic signed [65:0] prod;
    logic signed [66:0] rsh;
    logic signed [34:0] sum;
    logic signed [31:0] sat_sum, satv_sum;
    logic               div_start;
    logic signed [31:0] div_num;
    logic               div_busy;
    logic signed [31:0] div_q;
    logic signed [33:0] s_full;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x > 35'sh7fffffff)
            return 32'sh7fffffff;
        else if (x < -35'sh80000000)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [31:0] satv(input logic signed [34:0] x);
        if (x < 0)
            return '0;
        else if (x > 35'sh7fffffff)
            return 32'sh7fffffff;
        else
            return x[31:0];
    endfunction

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = {1'b0, 1'b0, dt_reg};
        mul_b = c01_reg;
        unique case (cmd.op)
            OP_P_M00:  begin mul_a = {2'b00, dt_reg}; mul_b = c01_reg; end
            OP_P_C:    begin mul_a = {2'b00, dt_reg}; mul_b = c11_reg; end
            OP_P_P00:  begin mul_a = {2'b00, dt_reg}; mul_b = c01_reg; end
            OP_P_POS:  begin mul_a = {2'b00, dt_reg}; mul_b = v_reg; end
            OP_U_POS:  begin mul_a = res_reg; mul_b = k0_reg; end
            OP_U_VEL:  begin mul_a = res_reg; mul_b = k1_reg; end
            OP_U_M00:  begin mul_a = 33'(a_reg); mul_b = c00_reg; end
            OP_U_M01:  begin mul_a = 33'(a_reg); mul_b = c01_reg; end
            OP_U_M10:  begin mul_a = 33'(b_reg); mul_b = c00_reg; end
            OP_U_M11:  begin mul_a = 33'(b_reg); mul_b = c01_reg; end
            OP_U_KR0:  begin mul_a = {2'b00, r_reg}; mul_b = k0_reg; end
            OP_U_KR1:  begin mul_a = {2'b00, r_reg}; mul_b = k1_reg; end
            OP_U_C00A: begin mul_a = 33'(m00_reg); mul_b = a_reg; end
            OP_U_C00B: begin mul_a = 33'(kr0_reg); mul_b = k0_reg; end
            OP_U_C01A: begin mul_a = 33'(m00_reg); mul_b = b_reg; end
            OP_U_C01B: begin mul_a = 33'(kr0_reg); mul_b = k1_reg; end
            OP_U_C11A: begin mul_a = 33'(m10_reg); mul_b = b_reg; end
            OP_U_C11B: begin mul_a = 33'(kr1_reg); mul_b = k1_reg; end
            default:   begin mul_a = {2'b00, dt_reg}; mul_b = c01_reg; end
        endcase
    end

    // product, rounded to nearest (floor of x + half), saturated
    assign prod = mul_a * mul_b;
    assign rsh  = (67'(prod) + HALF) >>> FRAC_BITS;
    always_comb
    begin
        if (rsh > 67'sh7fffffff)
            mp = 32'sh7fffffff;
        else if (rsh < -67'sh80000000)
            mp = 32'sh80000000;
        else
            mp = rsh[31:0];
    end

    // adder after the multiplier
    always_comb
    begin
        sum = 35'(mp);
        unique case (cmd.op)
            OP_P_M00:  sum = 35'(mp) + 35'(c00_reg);
            OP_P_C:    sum = 35'(mp) + 35'(c01_reg);
            OP_P_P00:  sum = 35'(mp) + 35'(t0_reg) + 35'($signed({1'b0, q_reg}));
            OP_P_POS:  sum = 35'(mp) + 35'(p_reg);
            OP_U_POS:  sum = 35'(mp) + 35'(p_reg);
            OP_U_VEL:  sum = 35'(mp) + 35'(v_reg);
            OP_U_M10:  sum = 35'(mp) + 35'(c01_reg);
            OP_U_M11:  sum = 35'(mp) + 35'(c11_reg);
            OP_U_C00B: sum = 35'(mp) + acc_reg;
            OP_U_C01A: sum = 35'(mp) + 35'(m01_reg);
            OP_U_C01B: sum = 35'(mp) + acc_reg;
            OP_U_C11A: sum = 35'(mp) + 35'(m11_reg);
            OP_U_C11B: sum = 35'(mp) + acc_reg;
            default:   sum = 35'(mp);
        endcase
    end
    assign sat_sum  = sat32(sum);
    assign satv_sum = satv(sum);

    assign s_full    = 34'(c00_reg) + 34'($signed({1'b0, r_reg}));
    assign div_start = (cmd.op == OP_U_DIV0) || (cmd.op == OP_U_K0);
    assign div_num   = (cmd.op == OP_U_K0) ? c01_reg : c00_reg;

    kt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_mag_reg),
        .busy  (div_busy),
        .quo   (div_q)
    );

    // configuration and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg   <= 31'd1 << FRAC_BITS;
            q_reg    <= 31'd1 << FRAC_BITS;
            r_reg    <= 31'd1 << FRAC_BITS;
            ip_reg   <= '0;
            iv_reg   <= '0;
            ipv_reg  <= 31'd1 << FRAC_BITS;
            ivv_reg  <= 31'd1 << FRAC_BITS;
            p_reg    <= '0;
            v_reg    <= '0;
            c00_reg  <= 32'sd1 <<< FRAC_BITS;
            c01_reg  <= '0;
            c11_reg  <= 32'sd1 <<< FRAC_BITS;
            sing_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DT:   dt_reg <= cfg_data[30:0];
                CFG_Q:    q_reg  <= cfg_data[30:0];
                CFG_R:    r_reg  <= cfg_data[30:0];
                CFG_POS:  begin ip_reg <= cfg_data; p_reg <= cfg_data; end
                CFG_VEL:  begin iv_reg <= cfg_data; v_reg <= cfg_data; end
                CFG_PVAR: begin
                    ipv_reg <= cfg_data[30:0];
                    c00_reg <= {1'b0, cfg_data[30:0]};
                    c01_reg <= '0;
                end
                CFG_VVAR: begin
                    ivv_reg <= cfg_data[30:0];
                    c11_reg <= {1'b0, cfg_data[30:0]};
                    c01_reg <= '0;
                end
                default: ;
            endcase
        end
        else
        begin
            if (load_z)
                sing_reg <= 1'b0;
            unique case (cmd.op)
                OP_P_C:    c01_reg <= sat_sum;
                OP_P_P00:  begin
                    c00_reg <= satv_sum;
                    c11_reg <= satv(35'(c11_reg) + 35'($signed({1'b0, q_reg})));
                end
                OP_P_POS:  p_reg <= sat_sum;
                OP_U_S:    sing_reg <= (s_full <= 0);
                OP_U_POS:  p_reg <= sat_sum;
                OP_U_VEL:  v_reg <= sat_sum;
                OP_U_C11B: begin
                    c00_reg <= n00_reg;
                    c01_reg <= n01_reg;
                    c11_reg <= satv_sum;
                end
                default: ;
            endcase
        end
    end

    // scratch registers
    always_ff @(posedge clk)
    begin
        if (load_z)
            z_reg <= 33'(z_in);
        unique case (cmd.op)
            OP_P_M00:  t0_reg <= sat_sum;
            OP_U_S:    begin
                s_mag_reg <= s_full[31:0];
                s_den_reg <= s_full[31:0];
                res_reg   <= z_reg - 33'(p_reg);
            end
            OP_U_K0:   k0_reg <= div_q;
            OP_U_K1:   k1_reg <= div_q;
            OP_U_AB:   begin
                a_reg <= sat32(35'(ONE) - 35'(k0_reg));
                b_reg <= sat32(-35'(k1_reg));
            end
            OP_U_M00:  m00_reg <= mp;
            OP_U_M01:  m01_reg <= mp;
            OP_U_M10:  m10_reg <= sat_sum;
            OP_U_M11:  m11_reg <= sat_sum;
            OP_U_KR0:  kr0_reg <= mp;
            OP_U_KR1:  kr1_reg <= mp;
            OP_U_C00A: acc_reg <= 35'(mp);
            OP_U_C00B: n00_reg <= satv_sum;
            OP_U_C01A: acc_reg <= sum;
            OP_U_C01B: n01_reg <= sat_sum;
            OP_U_C11A: acc_reg <= sum;
            default: ;
        endcase
    end

    assign stat.div_busy = div_busy;
    assign stat.singular = sing_reg;
    assign pos  = p_reg;
    assign vel  = v_reg;
    assign pvar = c00_reg[30:0];

    // initial registers only feed the state on a write; keep them observable
    logic unused_init;
    assign unused_init = ^{ip_reg, iv_reg, ipv_reg, ivv_reg, s_den_reg};
endmodule

FILE: src/kt_ctrl.sv
// ----------------------------------------------------------------------------
// kt_ctrl
// sequencer that steps the datapath through predict and update
// ----------------------------------------------------------------------------
module kt_ctrl
    import kt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_req,
    output logic       in_ready,
    output logic       load_z,
    input  kt_stat_t   stat,
    input  logic       out_hold,
    output kt_cmd_t    cmd,
    output logic       res_load
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [4:0] op_reg, op_next;
    logic       upd_reg, upd_next;
    logic       wk1_reg, wk1_next;

    assign in_ready = (state_reg == S_IDLE);
    assign load_z   = in_valid && in_ready;
    assign cmd.op   = (state_reg == S_RUN) ? op_reg : OP_NOP;
    assign res_load = (state_reg == S_DONE) && !out_hold;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        upd_next   = upd_reg;
        wk1_next   = wk1_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    upd_next = (in_req == REQ_UPDATE) || (in_req == REQ_BOTH);
                    if ((in_req == REQ_PREDICT) || (in_req == REQ_BOTH))
                    begin
                        op_next    = OP_P_M00;
                        state_next = S_RUN;
                    end
                    else if (in_req == REQ_UPDATE)
                    begin
                        op_next    = OP_U_S;
                        state_next = S_RUN;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_RUN:
            begin
                if (op_reg == OP_P_POS)
                begin
                    if (upd_reg)
                        op_next = OP_U_S;
                    else
                        state_next = S_DONE;
                end
                else if (op_reg == OP_U_S)
                    op_next = OP_U_DIV0;
                else if (op_reg == OP_U_DIV0)
                begin
                    wk1_next   = 1'b0;
                    state_next = S_WAIT;
                end
                else if (op_reg == OP_U_K0)
                begin
                    wk1_next   = 1'b1;
                    state_next = S_WAIT;
                end
                else if (op_reg == OP_U_C11B)
                    state_next = S_DONE;
                else
                    op_next = op_reg + 5'd1;
            end
            S_WAIT:
            begin
                // singular case: skip the whole update
                if (stat.singular)
                    state_next = S_DONE;
                else if (!stat.div_busy && op_reg != OP_U_DIV0 && !wk1_reg)
                    state_next = S_WAIT;
                else if (!stat.div_busy)
                begin
                    op_next    = wk1_reg ? OP_U_K1 : OP_U_K0;
                    state_next = S_RUN;
                end
            end
            S_DONE:
            begin
                // stay until the output register can take the result
                if (!out_hold)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NOP;
            upd_reg   <= 1'b0;
            wk1_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            upd_reg   <= upd_next;
            wk1_reg   <= wk1_next;
        end
    end
endmodule

FILE: src/kalman_tracker_pos_vel.sv
// ----------------------------------------------------------------------------
// kalman_tracker_pos_vel
// two-state constant-velocity tracker in signed fixed point
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (req_type, measured_position) and one result
// item leaves on out_ch per input item. Configuration is written through
// cfg_we / cfg_index / cfg_data while the block is idle; writing an initial
// value loads the matching state word at once.
// One item is worked at a time; the next item is taken in the cycle after
// the result is loaded. An update runs two 48-step serial divisions besides
// its sequencing and multiplier steps; predict then update runs both parts,
// and request code three goes straight to a result. The single shared
// multiplier and the one-bit-per-cycle divider set the pace of the work.
// Reset loads dt, q, r and both variances with 1.0, state to zero.
// A result waits in an output register while out_ch.ready is low; a new
// item can be accepted and worked meanwhile, but it finishes only after the
// waiting result is taken.
// ----------------------------------------------------------------------------
module kalman_tracker_pos_vel
    import kt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    kt_in_if.sink       in_ch,
    kt_out_if.source    out_ch
);
    kt_cmd_t  cmd;
    kt_stat_t stat;
    logic     load_z, res_load, ctrl_valid, ctrl_ready;
    logic signed [31:0] pos, vel;
    logic [30:0] pvar;
    logic        ovalid_reg;
    logic signed [31:0] opos_reg, ovel_reg;
    logic [30:0] ovar_reg;
    logic        oflag_reg;
    logic        hold;

    // controller holds in its done state while the output register is full and out_ch.ready is low
    assign hold       = ovalid_reg && !out_ch.ready;
    assign ctrl_valid = in_ch.valid;
    assign in_ch.ready = ctrl_ready;

    kt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n && 1'b1),
        .in_valid (ctrl_valid),
        .in_req   (in_ch.req_type),
        .in_ready (ctrl_ready),
        .load_z   (load_z),
        .stat     (stat),
        .out_hold (hold),
        .cmd      (cmd),
        .res_load (res_load)
    );

    kt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load_z    (load_z),
        .z_in      (in_ch.measured_position),
        .cmd       (cmd),
        .stat      (stat),
        .pos       (pos),
        .vel       (vel),
        .pvar      (pvar)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res_load)
            ovalid_reg <= 1'b1;
        else if (out_ch.ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            opos_reg  <= pos;
            ovel_reg  <= vel;
            ovar_reg  <= pvar;
            oflag_reg <= stat.singular;
        end
    end

    assign out_ch.valid                = ovalid_reg;
    assign out_ch.position_estimate    = opos_reg;
    assign out_ch.velocity_estimate    = ovel_reg;
    assign out_ch.position_uncertainty = ovar_reg;
    assign out_ch.singular_flag        = oflag_reg;
endmodule

FILE: src/kt_checker.sv
// ----------------------------------------------------------------------------
// kt_checker
// port-level checks of the tracker handshakes
// ----------------------------------------------------------------------------
`include "kalman_tracker_pos_vel_assert.svh"
module kt_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // output item held until taken
    `KT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out item dropped")
    // no new input while a result is still being formed right after accept
    `KT_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "second item taken")
    // a result never appears the cycle after accept when none was waiting
    `KT_ASSERT_NXT(a_no_instant, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid, "result too early")
endmodule

bind kalman_tracker_pos_vel kt_checker u_kt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);
